/* src/ray_ray_closest_points_assert.svh */
// Assertion macros shared by the checker.
`ifndef RAY_RAY_CLOSEST_POINTS_ASSERT_SVH
`define RAY_RAY_CLOSEST_POINTS_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define RRCP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray pair check failed");

// Condition that must hold at every rising edge outside reset.
`define RRCP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ray pair check failed");

`endif

/* src/rrcp_pkg.sv */
package rrcp_pkg;

  // Limb width of the partial products
  localparam int LIMB = 32;

  // Input and intermediate widths
  localparam int IN_W   = 32;
  localparam int DIFF_W = IN_W + 1;
  localparam int SQ_W   = 64;          // u.u and v.v, unsigned
  localparam int B_W    = 65;          // u.v, signed
  localparam int E_W    = 66;          // u.d and v.d, signed
  localparam int MA_W   = 65;          // first operand of a wide product
  localparam int MB_W   = 64;          // second operand of a wide product
  localparam int PROD_W = MA_W + MB_W; // magnitude of a wide product
  localparam int NPROD  = 6;

  // Determinant and numerators
  localparam int MAG_W  = 130;
  localparam int SMAG_W = MAG_W + 1;

  // Divider
  localparam int QW   = 32;
  localparam int RW   = MAG_W + QW;
  localparam int NDIV = 2;

  localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

  localparam logic [31:0] EPS_RESET = 32'd4295;

  // Data riding along the wide multiplier pipeline
  typedef struct packed {
    logic [SQ_W-1:0]       a;
    logic signed [E_W-1:0] e;
    logic                  s_ec;
    logic                  s_fb;
    logic                  s_af;
    logic                  s_be;
  } mul_side_t;

  // Result flags riding along the divider pipeline
  typedef struct packed {
    logic unique_sol;
    logic degen;
  } div_side_t;

endpackage

/* src/ray_ray_closest_points.sv */
// Closest points between two rays in signed fixed point. One ray pair is taken
// in every clock cycle and its result appears on the result ports, marked by
// done; results leave in the order the requests came. The wide terms pass
// through six stages of 32x32 limb products and the quotients through 32
// stages of the restoring divider, one quotient bit each. busy is high only
// during reset. done is a one-cycle strobe and the result must be taken in
// that cycle: there is no way to hold it off. parallel_epsilon is written
// through cfg_valid/cfg_data, always ready, and should only change while no
// request is in flight.
module ray_ray_closest_points import rrcp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_origin_x,
  input  logic signed [31:0] first_origin_y,
  input  logic signed [31:0] first_origin_z,
  input  logic signed [31:0] first_dir_x,
  input  logic signed [31:0] first_dir_y,
  input  logic signed [31:0] first_dir_z,
  input  logic signed [31:0] second_origin_x,
  input  logic signed [31:0] second_origin_y,
  input  logic signed [31:0] second_origin_z,
  input  logic signed [31:0] second_dir_x,
  input  logic signed [31:0] second_dir_y,
  input  logic signed [31:0] second_dir_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] param_first,
  output logic signed [31:0] param_second,
  output logic               unique_solution,
  output logic               degenerate_dir,
  output logic               saturated
);

  localparam int THR_SH = 4 * FRAC_BITS - 32;

  // Wide product lanes
  localparam int P_AC = 0;
  localparam int P_BB = 1;
  localparam int P_EC = 2;
  localparam int P_FB = 3;
  localparam int P_AF = 4;
  localparam int P_BE = 5;

  logic [31:0] parallel_epsilon;

  // Threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_epsilon <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      parallel_epsilon <= cfg_data;
    end
  end

  assign busy = rst;

  // Stage 1: directions and origin difference
  logic                     s1_vld;
  logic signed [IN_W-1:0]   s1_u [3];
  logic signed [IN_W-1:0]   s1_v [3];
  logic signed [DIFF_W-1:0] s1_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_u[0] <= first_dir_x;
    s1_u[1] <= first_dir_y;
    s1_u[2] <= first_dir_z;
    s1_v[0] <= second_dir_x;
    s1_v[1] <= second_dir_y;
    s1_v[2] <= second_dir_z;
    s1_d[0] <= DIFF_W'(second_origin_x) - DIFF_W'(first_origin_x);
    s1_d[1] <= DIFF_W'(second_origin_y) - DIFF_W'(first_origin_y);
    s1_d[2] <= DIFF_W'(second_origin_z) - DIFF_W'(first_origin_z);
  end

  // Stage 2: componentwise products
  logic                         s2_vld;
  logic signed [SQ_W-1:0]       p_uu [3];
  logic signed [SQ_W-1:0]       p_uv [3];
  logic signed [SQ_W-1:0]       p_vv [3];
  logic signed [IN_W+DIFF_W-1:0] p_ud [3];
  logic signed [IN_W+DIFF_W-1:0] p_vd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p_uu[k] <= SQ_W'(s1_u[k]) * SQ_W'(s1_u[k]);
      p_uv[k] <= SQ_W'(s1_u[k]) * SQ_W'(s1_v[k]);
      p_vv[k] <= SQ_W'(s1_v[k]) * SQ_W'(s1_v[k]);
      p_ud[k] <= (IN_W+DIFF_W)'(s1_u[k]) * (IN_W+DIFF_W)'(s1_d[k]);
      p_vd[k] <= (IN_W+DIFF_W)'(s1_v[k]) * (IN_W+DIFF_W)'(s1_d[k]);
    end
  end

  // Stage 3: dot products a, b, v.v, e, f
  logic signed [SQ_W+1:0] a_sum, b_sum, cm_sum;
  logic signed [E_W:0]    e_sum, f_sum;

  always_comb begin
    a_sum  = (SQ_W+2)'(p_uu[0]) + (SQ_W+2)'(p_uu[1]) + (SQ_W+2)'(p_uu[2]);
    b_sum  = (SQ_W+2)'(p_uv[0]) + (SQ_W+2)'(p_uv[1]) + (SQ_W+2)'(p_uv[2]);
    cm_sum = (SQ_W+2)'(p_vv[0]) + (SQ_W+2)'(p_vv[1]) + (SQ_W+2)'(p_vv[2]);
    e_sum  = (E_W+1)'(p_ud[0]) + (E_W+1)'(p_ud[1]) + (E_W+1)'(p_ud[2]);
    f_sum  = (E_W+1)'(p_vd[0]) + (E_W+1)'(p_vd[1]) + (E_W+1)'(p_vd[2]);
  end

  logic                  s3_vld;
  logic [SQ_W-1:0]       s3_a;
  logic [SQ_W-1:0]       s3_cm;
  logic signed [B_W-1:0] s3_b;
  logic signed [E_W-1:0] s3_e;
  logic signed [E_W-1:0] s3_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_a  <= a_sum[SQ_W-1:0];
    s3_cm <= cm_sum[SQ_W-1:0];
    s3_b  <= b_sum[B_W-1:0];
    s3_e  <= e_sum[E_W-1:0];
    s3_f  <= f_sum[E_W-1:0];
  end

  // Magnitudes and signs into the wide multiplier
  logic [MB_W-1:0] b_mag;
  logic [MA_W-1:0] e_mag, f_mag;
  logic            sb, se, sf;
  logic [MA_W-1:0] mul_a [NPROD];
  logic [MB_W-1:0] mul_b [NPROD];
  mul_side_t       mul_side;

  always_comb begin
    sb    = s3_b[B_W-1];
    se    = s3_e[E_W-1];
    sf    = s3_f[E_W-1];
    b_mag = sb ? MB_W'(-s3_b) : MB_W'(s3_b);
    e_mag = se ? MA_W'(-s3_e) : MA_W'(s3_e);
    f_mag = sf ? MA_W'(-s3_f) : MA_W'(s3_f);

    mul_a[P_AC] = MA_W'(s3_a);  mul_b[P_AC] = s3_cm;
    mul_a[P_BB] = MA_W'(b_mag); mul_b[P_BB] = b_mag;
    mul_a[P_EC] = e_mag;        mul_b[P_EC] = s3_cm;
    mul_a[P_FB] = f_mag;        mul_b[P_FB] = b_mag;
    mul_a[P_AF] = f_mag;        mul_b[P_AF] = s3_a;
    mul_a[P_BE] = e_mag;        mul_b[P_BE] = b_mag;

    mul_side.a    = s3_a;
    mul_side.e    = s3_e;
    mul_side.s_ec = ~se;
    mul_side.s_fb = sf ^ sb;
    mul_side.s_af = sf;
    mul_side.s_be = sb ^ se;
  end

  logic              m_vld;
  logic [PROD_W-1:0] m_prod [NPROD];
  mul_side_t         m_side;

  rrcp_umul u_umul (
    .clk       (clk),
    .rst       (rst),
    .valid     (s3_vld),
    .a         (mul_a),
    .b         (mul_b),
    .side      (mul_side),
    .valid_out (m_vld),
    .prod      (m_prod),
    .side_out  (m_side)
  );

  // Stage 4: determinant and Cramer numerators
  logic signed [SMAG_W-1:0] ps [NPROD];
  logic [NPROD-1:0]         psign;

  always_comb begin
    psign = {m_side.s_be, m_side.s_af, m_side.s_fb, m_side.s_ec, 1'b0, 1'b0};
    for (int l = 0; l < NPROD; l++) begin
      ps[l] = $signed({2'b00, m_prod[l]});
      if (psign[l]) ps[l] = -ps[l];
    end
  end

  logic                     s4_vld;
  logic signed [SMAG_W-1:0] s4_det, s4_n1, s4_n2;
  logic [SQ_W-1:0]          s4_a;
  logic signed [E_W-1:0]    s4_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_det <= ps[P_BB] - ps[P_AC];
    s4_n1  <= ps[P_EC] + ps[P_FB];
    s4_n2  <= ps[P_AF] - ps[P_BE];
    s4_a   <= m_side.a;
    s4_e   <= m_side.e;
  end

  // Stage 5: parallel test and divider operand select
  logic [MAG_W-1:0] det_abs, n1_abs, n2_abs, e_abs, thr;
  logic             par, a_zero;
  logic [MAG_W-1:0] num_sel [NDIV];
  logic [MAG_W-1:0] den_sel [NDIV];
  logic [NDIV-1:0]  neg_sel;
  div_side_t        flags_sel;

  always_comb begin
    det_abs = s4_det[SMAG_W-1] ? MAG_W'(-s4_det) : MAG_W'(s4_det);
    n1_abs  = s4_n1[SMAG_W-1] ? MAG_W'(-s4_n1) : MAG_W'(s4_n1);
    n2_abs  = s4_n2[SMAG_W-1] ? MAG_W'(-s4_n2) : MAG_W'(s4_n2);
    e_abs   = s4_e[E_W-1] ? MAG_W'(-s4_e) : MAG_W'(s4_e);
    thr     = MAG_W'(parallel_epsilon) << THR_SH;
    par     = (s4_det == '0) || (det_abs < thr);
    a_zero  = (s4_a == '0);

    // Defaults give a zero quotient
    num_sel[0] = '0;
    den_sel[0] = MAG_W'(1);
    num_sel[1] = '0;
    den_sel[1] = MAG_W'(1);
    neg_sel    = '0;
    if (!par) begin
      num_sel[0] = n1_abs;
      den_sel[0] = det_abs;
      neg_sel[0] = s4_n1[SMAG_W-1] ^ s4_det[SMAG_W-1];
      num_sel[1] = n2_abs;
      den_sel[1] = det_abs;
      neg_sel[1] = s4_n2[SMAG_W-1] ^ s4_det[SMAG_W-1];
    end else if (!a_zero) begin
      num_sel[0] = e_abs;
      den_sel[0] = MAG_W'(s4_a);
      neg_sel[0] = s4_e[E_W-1];
    end
    flags_sel.unique_sol = !par;
    flags_sel.degen      = par && a_zero;
  end

  logic             s5_vld;
  logic [MAG_W-1:0] s5_num [NDIV];
  logic [MAG_W-1:0] s5_den [NDIV];
  logic [NDIV-1:0]  s5_neg;
  div_side_t        s5_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_num   <= num_sel;
    s5_den   <= den_sel;
    s5_neg   <= neg_sel;
    s5_flags <= flags_sel;
  end

  // Dividers
  logic            d_vld;
  logic [QW-1:0]   d_quo [NDIV];
  logic [NDIV-1:0] d_ovf, d_neg;
  div_side_t       d_flags;

  rrcp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .valid     (s5_vld),
    .num       (s5_num),
    .den       (s5_den),
    .neg       (s5_neg),
    .side      (s5_flags),
    .valid_out (d_vld),
    .quo       (d_quo),
    .ovf_out   (d_ovf),
    .neg_out   (d_neg),
    .side_out  (d_flags)
  );

  // Saturation and sign
  logic [QW-1:0]   res [NDIV];
  logic [NDIV-1:0] sat_l;

  always_comb begin
    for (int l = 0; l < NDIV; l++) begin
      sat_l[l] = d_ovf[l] || (d_quo[l] > (d_neg[l] ? SAT_NEG : SAT_POS));
      if (sat_l[l]) begin
        res[l] = d_neg[l] ? SAT_NEG : SAT_POS;
      end else begin
        res[l] = d_neg[l] ? (QW'(0) - d_quo[l]) : d_quo[l];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    param_first     <= $signed(res[0]);
    param_second    <= $signed(res[1]);
    unique_solution <= d_flags.unique_sol;
    degenerate_dir  <= d_flags.degen;
    saturated       <= |sat_l;
  end

endmodule

/* src/rrcp_umul.sv */
// Six unsigned wide products, one 32x32 limb product per stage and lane.
module rrcp_umul import rrcp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  logic [MA_W-1:0]   a [NPROD],
  input  logic [MB_W-1:0]   b [NPROD],
  input  mul_side_t         side,
  output logic              valid_out,
  output logic [PROD_W-1:0] prod [NPROD],
  output mul_side_t         side_out
);

  localparam int NA    = (MA_W + LIMB - 1) / LIMB;
  localparam int NB    = (MB_W + LIMB - 1) / LIMB;
  localparam int STEPS = NA * NB;

  logic [NA*LIMB-1:0] a_pipe   [STEPS][NPROD];
  logic [NB*LIMB-1:0] b_pipe   [STEPS][NPROD];
  logic [PROD_W-1:0]  acc_pipe [STEPS+1][NPROD];
  mul_side_t          side_pipe [STEPS+1];
  logic [STEPS:0]     vld_pipe;

  // Stage inputs
  always_comb begin
    for (int l = 0; l < NPROD; l++) begin
      a_pipe[0][l]   = (NA*LIMB)'(a[l]);
      b_pipe[0][l]   = (NB*LIMB)'(b[l]);
      acc_pipe[0][l] = '0;
    end
    side_pipe[0] = side;
    vld_pipe[0]  = valid;
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int I = s / NB;
    localparam int J = s % NB;
    logic [2*LIMB-1:0] pp [NPROD];

    // One limb product per lane
    always_comb begin
      for (int l = 0; l < NPROD; l++) begin
        pp[l] = (2*LIMB)'(a_pipe[s][l][I*LIMB +: LIMB]) *
                (2*LIMB)'(b_pipe[s][l][J*LIMB +: LIMB]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_pipe[s+1] <= 1'b0;
      end else begin
        vld_pipe[s+1] <= vld_pipe[s];
      end
    end

    always_ff @(posedge clk) begin
      side_pipe[s+1] <= side_pipe[s];
      for (int l = 0; l < NPROD; l++) begin
        acc_pipe[s+1][l] <= acc_pipe[s][l] + (PROD_W'(pp[l]) << (LIMB*(I+J)));
      end
    end

    if (s < STEPS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        for (int l = 0; l < NPROD; l++) begin
          a_pipe[s+1][l] <= a_pipe[s][l];
          b_pipe[s+1][l] <= b_pipe[s][l];
        end
      end
    end
  end

  assign valid_out = vld_pipe[STEPS];
  assign side_out  = side_pipe[STEPS];
  always_comb begin
    for (int l = 0; l < NPROD; l++) prod[l] = acc_pipe[STEPS][l];
  end

endmodule

/* src/rrcp_div.sv */
// Two restoring dividers, one quotient bit per stage, with overflow check
// up front. Quotient is (num << FRAC_BITS) / den, 32 bits.
module rrcp_div import rrcp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  input  logic [MAG_W-1:0] num [NDIV],
  input  logic [MAG_W-1:0] den [NDIV],
  input  logic [NDIV-1:0]  neg,
  input  div_side_t        side,
  output logic             valid_out,
  output logic [QW-1:0]    quo [NDIV],
  output logic [NDIV-1:0]  ovf_out,
  output logic [NDIV-1:0]  neg_out,
  output div_side_t        side_out
);

  logic [RW-1:0]    r_pipe [QW][NDIV];
  logic [MAG_W-1:0] d_pipe [QW][NDIV];
  logic [QW-1:0]    q_pipe [QW+1][NDIV];
  logic [NDIV-1:0]  ovf_pipe [QW+1];
  logic [NDIV-1:0]  neg_pipe [QW+1];
  div_side_t        side_pipe [QW+1];
  logic [QW:0]      vld_pipe;

  // Scale numerator, flag quotients of 2^32 and above
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe[0] <= 1'b0;
    end else begin
      vld_pipe[0] <= valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NDIV; l++) begin
      r_pipe[0][l]   <= RW'(num[l]) << FRAC_BITS;
      d_pipe[0][l]   <= den[l];
      q_pipe[0][l]   <= '0;
      ovf_pipe[0][l] <= (RW'(num[l]) << FRAC_BITS) >= (RW'(den[l]) << QW);
    end
    neg_pipe[0]  <= neg;
    side_pipe[0] <= side;
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int K = QW - 1 - s;
    logic [RW:0]     diff   [NDIV];
    logic [RW-1:0]   r_next [NDIV];
    logic [QW-1:0]   q_next [NDIV];

    // Trial subtract of den << K
    always_comb begin
      for (int l = 0; l < NDIV; l++) begin
        diff[l]   = {1'b0, r_pipe[s][l]} - {1'b0, (RW'(d_pipe[s][l]) << K)};
        r_next[l] = diff[l][RW] ? r_pipe[s][l] : diff[l][RW-1:0];
        q_next[l] = q_pipe[s][l];
        q_next[l][K] = ~diff[l][RW];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_pipe[s+1] <= 1'b0;
      end else begin
        vld_pipe[s+1] <= vld_pipe[s];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < NDIV; l++) begin
        q_pipe[s+1][l] <= q_next[l];
      end
      ovf_pipe[s+1]  <= ovf_pipe[s];
      neg_pipe[s+1]  <= neg_pipe[s];
      side_pipe[s+1] <= side_pipe[s];
    end

    // Remainder of the last step is not needed
    if (s < QW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        for (int l = 0; l < NDIV; l++) begin
          d_pipe[s+1][l] <= d_pipe[s][l];
          r_pipe[s+1][l] <= r_next[l];
        end
      end
    end
  end

  assign valid_out = vld_pipe[QW];
  assign ovf_out   = ovf_pipe[QW];
  assign neg_out   = neg_pipe[QW];
  assign side_out  = side_pipe[QW];
  always_comb begin
    for (int l = 0; l < NDIV; l++) quo[l] = q_pipe[QW][l];
  end

endmodule

/* src/rrcp_check.sv */
`include "ray_ray_closest_points_assert.svh"

// Port-level checks on the result stream.
module rrcp_check (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [31:0] param_first,
  input logic [31:0] param_second,
  input logic        unique_solution,
  input logic        degenerate_dir,
  input logic        saturated
);

  logic first_clamp, second_clamp, params_zero;

  // Clamp values and zero parameters seen on the ports
  assign first_clamp  = (param_first == 32'h7FFF_FFFF) || (param_first == 32'h8000_0000);
  assign second_clamp = (param_second == 32'h7FFF_FFFF) || (param_second == 32'h8000_0000);
  assign params_zero  = (param_first == 32'h0) && (param_second == 32'h0);

  // Zero first direction gives zero parameters on the fallback path
  `RRCP_ASSERT_IMPL(a_degen_zero, done && degenerate_dir, !unique_solution && params_zero)

  // Fallback path leaves the second parameter at zero
  `RRCP_ASSERT_IMPL(a_par_second, done && !unique_solution, param_second == 32'h0)

  // A clamp flag needs a clamp value on one of the parameters
  `RRCP_ASSERT_IMPL(a_sat_value, done && saturated, first_clamp || second_clamp)

  // No result strobe in the cycle after reset
  `RRCP_ASSERT_IMPL(a_done_reset, done, !$past(rst))

endmodule

bind ray_ray_closest_points rrcp_check u_check (
  .clk             (clk),
  .rst             (rst),
  .done            (done),
  .param_first     (param_first),
  .param_second    (param_second),
  .unique_solution (unique_solution),
  .degenerate_dir  (degenerate_dir),
  .saturated       (saturated)
);

/* tb/sv/testbench.sv */
module testbench import rrcp_pkg::*;;

  localparam int FRAC     = 16;
  localparam int WIDE     = 256;
  localparam int LATENCY  = 45;
  localparam int MAX_CYC  = 400000;

  // Field order: first origin xyz, first dir xyz, second origin xyz, second dir xyz
  typedef logic signed [31:0] ray_pair_t [12];

  typedef struct {
    logic [31:0] t1;
    logic [31:0] t2;
    logic        uniq;
    logic        degen;
    logic        sat;
  } closest_t;

  // Closest-point predictor and expected-result store
  class closest_board;
    closest_t   pending[$];
    logic [31:0] eps;
    int         errors;

    function new();
      eps = EPS_RESET;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    // (num << FRAC) / den, truncated toward zero, clamped to 32 bits
    function logic [31:0] quotient(logic signed [WIDE-1:0] num,
                                   logic signed [WIDE-1:0] den, inout logic sat);
      logic             neg;
      logic [WIDE-1:0]  mag_n, mag_d, q, lim;
      neg   = num[WIDE-1] != den[WIDE-1];
      mag_n = num[WIDE-1] ? -num : num;
      mag_d = den[WIDE-1] ? -den : den;
      q     = (mag_n << FRAC) / mag_d;
      lim   = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
      if (q > lim) begin
        sat = 1'b1;
        return neg ? SAT_NEG : SAT_POS;
      end
      return neg ? 32'(-q[31:0]) : q[31:0];
    endfunction

    function void note_request(ray_pair_t r);
      logic signed [WIDE-1:0] u[3], v[3], d[3];
      logic signed [WIDE-1:0] a, b, c, e, f, det, mag, thr;
      closest_t x;
      logic par;
      x = '{default: '0};
      for (int i = 0; i < 3; i++) begin
        u[i] = WIDE'(r[3 + i]);
        v[i] = WIDE'(r[9 + i]);
        d[i] = WIDE'(r[6 + i]) - WIDE'(r[i]);
      end
      a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
      b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
      c = -(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]);
      e = u[0]*d[0] + u[1]*d[1] + u[2]*d[2];
      f = v[0]*d[0] + v[1]*d[1] + v[2]*d[2];
      det = a*c + b*b;
      mag = det[WIDE-1] ? -det : det;
      thr = WIDE'({1'b0, eps}) << (4*FRAC - 32);
      par = (det == 0) || (mag < thr);
      if (!par) begin
        x.t1 = quotient(e*c + f*b, det, x.sat);
        x.t2 = quotient(a*f - b*e, det, x.sat);
      end else if (a == 0) begin
        x.degen = 1'b1;
      end else begin
        x.t1 = quotient(e, a, x.sat);
      end
      x.uniq = !par;
      pending.push_back(x);
    endfunction

    task check_result(closest_t got);
      closest_t w;
      if (pending.size() == 0) begin
        report("unexpected result", got.t1, 32'h0);
        return;
      end
      w = pending.pop_front();
      if (got.t1 !== w.t1) report("param_first", got.t1, w.t1);
      if (got.t2 !== w.t2) report("param_second", got.t2, w.t2);
      if (got.uniq !== w.uniq) report("unique_solution", 32'(got.uniq), 32'(w.uniq));
      if (got.degen !== w.degen) report("degenerate_dir", 32'(got.degen), 32'(w.degen));
      if (got.sat !== w.sat) report("saturated", 32'(got.sat), 32'(w.sat));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] fox = '0, foy = '0, foz = '0, fdx = '0, fdy = '0, fdz = '0;
  logic signed [31:0] sox = '0, soy = '0, soz = '0, sdx = '0, sdy = '0, sdz = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic done;
  logic signed [31:0] param_first, param_second;
  logic unique_solution, degenerate_dir, saturated;

  closest_board board;
  int cycles = 0;
  int gap_pct = 0;

  ray_ray_closest_points #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_origin_x(fox), .first_origin_y(foy), .first_origin_z(foz),
    .first_dir_x(fdx), .first_dir_y(fdy), .first_dir_z(fdz),
    .second_origin_x(sox), .second_origin_y(soy), .second_origin_z(soz),
    .second_dir_x(sdx), .second_dir_y(sdy), .second_dir_z(sdz),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .param_first(param_first), .param_second(param_second),
    .unique_solution(unique_solution), .degenerate_dir(degenerate_dir),
    .saturated(saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    closest_t r;
    if (!rst && done && board != null) begin
      r.t1 = param_first;
      r.t2 = param_second;
      r.uniq = unique_solution;
      r.degen = degenerate_dir;
      r.sat = saturated;
      board.check_result(r);
    end
  end

  // Present one request and hold it until accepted; start stays high afterward
  task send_request(ray_pair_t r);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    fox <= r[0]; foy <= r[1]; foz <= r[2];
    fdx <= r[3]; fdy <= r[4]; fdz <= r[5];
    sox <= r[6]; soy <= r[7]; soz <= r[8];
    sdx <= r[9]; sdy <= r[10]; sdz <= r[11];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_request(r);
  endtask

  // Drain the pipeline, then write the threshold register
  task write_epsilon(logic [31:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.eps = val;
  endtask

  function logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 8) == 0 ? 32'sh7FFF_FFFF : 32'(int'($urandom_range(0, 2048)) - 1024);
      default: return 32'(int'($urandom_range(0, 524288)) - 262144);
    endcase
  endfunction

  // Random ray pair: wide values, tiny directions, parallel or zero directions
  function ray_pair_t random_pair();
    ray_pair_t r;
    int kind, k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++)
      r[i] = pick_value((kind < 3) ? 0 : (kind < 6 ? 1 : 2));
    if (kind == 6) begin
      k = int'($urandom_range(0, 6)) - 3;
      for (int i = 0; i < 3; i++) r[9 + i] = r[3 + i] * k;
    end else if (kind == 7) begin
      for (int i = 0; i < 3; i++) r[3 + i] = '0;
    end else if (kind == 8) begin
      for (int i = 0; i < 3; i++) r[9 + i] = r[3 + i] + 32'(int'($urandom_range(0, 2)) - 1);
    end
    return r;
  endfunction

  task directed_requests();
    ray_pair_t r;
    logic signed [31:0] one;
    one = 32'sh0001_0000;
    r = '{default: '0}; send_request(r);
    r = '{default: 32'sh7FFF_FFFF}; send_request(r);
    r = '{default: 32'sh8000_0000}; send_request(r);
    r = '{default: 32'shFFFF_FFFF}; send_request(r);
    // zero first direction, other fields busy
    r = '{default: 32'sh0003_0000}; r[3] = 0; r[4] = 0; r[5] = 0; send_request(r);
    // orthogonal unit directions, skew lines
    r = '{default: '0}; r[3] = one; r[10] = one; r[8] = one; r[6] = one; send_request(r);
    // identical directions: exact parallel
    r = '{default: '0}; r[3] = one; r[9] = one; r[6] = 32'sh0005_0000; send_request(r);
    // opposite directions
    r = '{default: '0}; r[4] = one; r[10] = -one; r[7] = -32'sh0002_0000; send_request(r);
    // nearly parallel with far offsets: saturation
    r = '{default: '0}; r[3] = one; r[9] = one; r[10] = 1;
    r[6] = 32'sh7FFF_FFFF; r[0] = 32'sh8000_0000; r[7] = 32'sh7FFF_FFFF; send_request(r);
    r[7] = 32'sh8000_0000; r[1] = 32'sh7FFF_FFFF; send_request(r);
    // tiny first direction with large offset along it
    r = '{default: '0}; r[3] = 1; r[6] = 32'sh7FFF_FFFF; r[0] = 32'sh8000_0000; send_request(r);
    r[3] = -1; send_request(r);
    // extreme directions mixed
    r = '{default: '0}; r[3] = 32'sh8000_0000; r[4] = 32'sh7FFF_FFFF;
    r[11] = 32'sh8000_0000; r[6] = one; send_request(r);
    // tiny non-parallel directions near the threshold
    r = '{default: '0}; r[3] = 16; r[10] = 16; r[8] = one; send_request(r);
    r[3] = 256; r[10] = 256; send_request(r);
  endtask

  initial begin
    int n;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_requests();
    write_epsilon(32'd0);
    directed_requests();
    write_epsilon(32'hFFFF_FFFF);
    directed_requests();

    // random phases: sender gaps 9%, then 58%, then none
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: gap_pct = 9;
        1: gap_pct = 58;
        default: gap_pct = 0;
      endcase
      case (ph)
        1: write_epsilon($urandom());
        2: write_epsilon(32'd0);
        3: write_epsilon(32'hFFFF_FFFF);
        4: write_epsilon($urandom_range(0, 65535));
        5: write_epsilon(EPS_RESET);
        default: ;
      endcase
      n = 0;
      while (n < 260) begin
        send_request(random_pair());
        n++;
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/rrcp_pkg.sv
src/rrcp_umul.sv
src/rrcp_div.sv
src/ray_ray_closest_points.sv
src/rrcp_check.sv
tb/sv/testbench.sv
